// File: rtl/core/imlc_pkg.sv
package imlc_pkg;

   // Request kinds carried on req_type
   localparam logic [2:0] REQ_SPEED   = 3'd0;
   localparam logic [2:0] REQ_SETTING = 3'd1;
   localparam logic [2:0] REQ_ENCODER = 3'd2;
   localparam logic [2:0] REQ_PROBE   = 3'd3;
   localparam logic [2:0] REQ_STATUS  = 3'd4;
   localparam logic [2:0] REQ_TICK    = 3'd5;

   // Bus commands toward the byte engine
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_SEND  = 3'd2;
   localparam logic [2:0] CMD_RXACK = 3'd3;
   localparam logic [2:0] CMD_RXNAK = 3'd4;
   localparam logic [2:0] CMD_STOP  = 3'd5;

   // Byte-engine status codes, compared with the low three bits masked
   localparam logic [7:0] ST_START  = 8'h08;
   localparam logic [7:0] ST_SLAW   = 8'h18;
   localparam logic [7:0] ST_TXDATA = 8'h28;
   localparam logic [7:0] ST_SLAR   = 8'h40;
   localparam logic [7:0] ST_RXACK  = 8'h50;
   localparam logic [7:0] ST_RXNAK  = 8'h58;
   localparam logic [7:0] ST_MASK   = 8'hF8;

   // Register map
   localparam int unsigned     CSR_ADDR_W      = 3;
   localparam logic            CSR_IDX_DEVADDR = 1'b0;
   localparam logic            CSR_IDX_TIMEOUT = 1'b1;
   localparam logic [6:0]      DEVADDR_RESET   = 7'd0;
   localparam logic [15:0]     TIMEOUT_RESET   = 16'd1000;

   typedef struct packed {
      logic [6:0]  dev_addr;
      logic [15:0] timeout;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [13:0] speed_value;
      logic [7:0]         setting_byte;
      logic [7:0]         bus_status;
      logic [7:0]         rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         bus_command;
      logic [7:0]         bus_byte;
      logic               done_res;
      logic               success;
      logic               device_present;
      logic signed [31:0] encoder_count;
   } rsp_item_type;

endpackage

// File: rtl/core/imlc_csr.sv
module imlc_csr
   import imlc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [6:0]  dev_addr_ff;
   logic [15:0] timeout_ff;
   logic        wr_en;
   logic        idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DEVADDR_RESET;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (wr_en) begin
         unique case (idx)
            CSR_IDX_DEVADDR: dev_addr_ff <= pwdata[6:0];
            CSR_IDX_TIMEOUT: timeout_ff  <= pwdata[15:0];
            default:         dev_addr_ff <= dev_addr_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_IDX_DEVADDR: prdata = {25'd0, dev_addr_ff};
         CSR_IDX_TIMEOUT: prdata = {16'd0, timeout_ff};
         default:         prdata = 32'd0;
      endcase
   end

   assign cfg = {dev_addr_ff, timeout_ff};

endmodule

// File: rtl/core/imlc_seq.sv
module imlc_seq
   import imlc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  req_item_type item,
   input  logic         fire,
   output logic         emit,
   output rsp_item_type rsp
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_ADDR  = 3'd2;
   localparam logic [2:0] PH_DATA  = 3'd3;
   localparam logic [2:0] PH_RX    = 3'd4;

   logic [2:0]  phase_ff,   phase_in;
   logic [1:0]  active_ff,  active_in;
   logic [1:0]  bidx_ff,    bidx_in;
   logic [7:0]  hi_byte_ff, hi_byte_in;
   logic [7:0]  lo_byte_ff, lo_byte_in;
   logic [31:0] enc_ff,     enc_in;
   logic [15:0] tick_ff,    tick_in;

   logic [7:0]  st;
   logic [7:0]  addr_w;
   logic        neg;
   logic [13:0] mag_raw;
   logic [11:0] mag;

   function automatic rsp_item_type make_rsp(logic [2:0] cmd, logic [7:0] byte_v,
                                             logic done, logic ok, logic present,
                                             logic [31:0] enc);
      rsp_item_type r;
      r.bus_command    = cmd;
      r.bus_byte       = byte_v;
      r.done_res       = done;
      r.success        = ok;
      r.device_present = present;
      r.encoder_count  = enc;
      return r;
   endfunction

   assign st     = item.bus_status & ST_MASK;
   assign addr_w = {cfg.dev_addr, 1'b0};

   // Saturate the speed magnitude to 12 bits
   assign neg     = item.speed_value[13];
   assign mag_raw = neg ? (14'd0 - item.speed_value) : item.speed_value;
   assign mag     = (mag_raw[13:12] != 2'b00) ? 12'hFFF : mag_raw[11:0];

   always_comb begin
      phase_in   = phase_ff;
      active_in  = active_ff;
      bidx_in    = bidx_ff;
      hi_byte_in = hi_byte_ff;
      lo_byte_in = lo_byte_ff;
      enc_in     = enc_ff;
      tick_in    = tick_ff;
      emit       = 1'b0;
      rsp        = make_rsp(CMD_NONE, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0);

      case (item.kind) inside
         REQ_SPEED, REQ_SETTING, REQ_ENCODER, REQ_PROBE: begin
            if (phase_ff == PH_IDLE) begin
               active_in  = item.kind[1:0];
               bidx_in    = 2'd0;
               tick_in    = 16'd0;
               enc_in     = 32'd0;
               hi_byte_in = 8'd0;
               lo_byte_in = 8'd0;
               if (item.kind == REQ_SPEED) begin
                  hi_byte_in = {2'b00, neg, mag[11:7]};
                  lo_byte_in = {1'b1, mag[6:0]};
               end else if (item.kind == REQ_SETTING) begin
                  lo_byte_in = item.setting_byte;
               end
               phase_in = PH_START;
               emit     = 1'b1;
               rsp      = make_rsp(CMD_START, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0);
            end
         end
         REQ_STATUS: begin
            if (phase_ff != PH_IDLE) begin
               emit = 1'b1;
               // Default outcome is a failed stop; good statuses override below
               rsp      = make_rsp(CMD_STOP, 8'd0, 1'b1, 1'b0, 1'b0, 32'd0);
               phase_in = PH_IDLE;
               bidx_in  = 2'd0;
               tick_in  = 16'd0;
               unique case (phase_ff)
                  PH_START: begin
                     if (st == ST_START) begin
                        phase_in = PH_ADDR;
                        bidx_in  = bidx_ff;
                        rsp      = make_rsp(CMD_SEND,
                                            addr_w | {7'd0, active_ff == REQ_ENCODER[1:0]},
                                            1'b0, 1'b0, 1'b0, 32'd0);
                     end
                  end
                  PH_ADDR: begin
                     if (active_ff == REQ_PROBE[1:0]) begin
                        if (st == ST_SLAW)
                           rsp = make_rsp(CMD_STOP, 8'd0, 1'b1, 1'b1, 1'b1, 32'd0);
                     end else if (st == ST_SLAW || st == ST_SLAR) begin
                        tick_in = tick_ff;
                        if (active_ff == REQ_ENCODER[1:0]) begin
                           phase_in = PH_RX;
                           enc_in   = 32'd0;
                           rsp      = make_rsp(CMD_RXACK, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0);
                        end else begin
                           phase_in = PH_DATA;
                           rsp      = make_rsp(CMD_SEND,
                                               (active_ff == REQ_SPEED[1:0]) ? hi_byte_ff
                                                                             : lo_byte_ff,
                                               1'b0, 1'b0, 1'b0, 32'd0);
                        end
                     end
                  end
                  PH_DATA: begin
                     if (st == ST_TXDATA) begin
                        if (active_ff == REQ_SPEED[1:0] && bidx_ff == 2'd0) begin
                           phase_in = PH_DATA;
                           bidx_in  = 2'd1;
                           tick_in  = tick_ff;
                           rsp      = make_rsp(CMD_SEND, lo_byte_ff, 1'b0, 1'b0, 1'b0, 32'd0);
                        end else begin
                           rsp = make_rsp(CMD_STOP, 8'd0, 1'b1, 1'b1, 1'b0, 32'd0);
                        end
                     end
                  end
                  PH_RX: begin
                     if (bidx_ff != 2'd3) begin
                        if (st == ST_RXACK) begin
                           // Shift in big-endian: first byte ends up on top
                           enc_in   = {enc_ff[23:0], item.rx_byte};
                           phase_in = PH_RX;
                           bidx_in  = bidx_ff + 2'd1;
                           tick_in  = tick_ff;
                           rsp      = make_rsp((bidx_ff == 2'd2) ? CMD_RXNAK : CMD_RXACK,
                                               8'd0, 1'b0, 1'b0, 1'b0, 32'd0);
                        end
                     end else if (st == ST_RXNAK) begin
                        enc_in = {enc_ff[23:0], item.rx_byte};
                        rsp    = make_rsp(CMD_STOP, 8'd0, 1'b1, 1'b1, 1'b0,
                                          {enc_ff[23:0], item.rx_byte});
                     end
                  end
                  default: begin
                     emit     = 1'b0;
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
         REQ_TICK: begin
            if (phase_ff == PH_ADDR && active_ff == REQ_PROBE[1:0]) begin
               if (tick_ff >= cfg.timeout) begin
                  emit     = 1'b1;
                  rsp      = make_rsp(CMD_STOP, 8'd0, 1'b1, 1'b0, 1'b0, 32'd0);
                  phase_in = PH_IDLE;
                  bidx_in  = 2'd0;
                  tick_in  = 16'd0;
               end else begin
                  tick_in = tick_ff + 16'd1;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         active_ff  <= 2'd0;
         bidx_ff    <= 2'd0;
         hi_byte_ff <= 8'd0;
         lo_byte_ff <= 8'd0;
         enc_ff     <= 32'd0;
         tick_ff    <= 16'd0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         active_ff  <= active_in;
         bidx_ff    <= bidx_in;
         hi_byte_ff <= hi_byte_in;
         lo_byte_ff <= lo_byte_in;
         enc_ff     <= enc_in;
         tick_ff    <= tick_in;
      end
   end

endmodule

// File: rtl/core/imlc_rspq.sv
module imlc_rspq
   import imlc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type head
);

   logic         head_vld_ff, head_vld_in;
   logic         skid_vld_ff, skid_vld_in;
   rsp_item_type head_ff,     head_in;
   rsp_item_type skid_ff,     skid_in;
   logic         pop;

   assign pop       = head_vld_ff & ~rsp_stall;
   assign full      = skid_vld_ff;
   assign rsp_valid = head_vld_ff;
   assign head      = head_ff;

   always_comb begin
      head_vld_in = head_vld_ff;
      skid_vld_in = skid_vld_ff;
      head_in     = head_ff;
      skid_in     = skid_ff;
      if (pop) begin
         if (skid_vld_ff) begin
            // Advance the skid beat into the head
            head_in = skid_ff;
            if (push) begin
               skid_in = push_data;
            end else begin
               skid_vld_in = 1'b0;
            end
         end else if (push) begin
            head_in = push_data;
         end else begin
            head_vld_in = 1'b0;
         end
      end else if (push) begin
         if (!head_vld_ff) begin
            head_in     = push_data;
            head_vld_in = 1'b1;
         end else begin
            skid_in     = push_data;
            skid_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// File: rtl/core/i2c_motor_link_controller_unit.sv
// I2C master transaction sequencer for a motor driver link. Each beat on the
// req_ channel is one event: a new request (speed, setting byte, encoder read,
// presence probe), a byte-engine status report, or a microsecond tick. The
// block answers each event with at most one rsp_ beat carrying the next bus
// command (start, send byte, receive ACK/NACK, stop) and, on the final stop,
// done/success, the probe result and the assembled encoder value. Statuses are
// compared with their low three bits masked. Requests while a transaction is
// running, statuses while idle, stray ticks and unused codes give no beat.
// Speeds saturate to +/-4095 and go out as a sign-plus-5-bit byte and a
// flagged 7-bit byte; the probe gives up on the tick after probe_timeout_ticks
// have counted. Timing: an accepted beat is registered, decided combinationally
// and lands in a two-entry output buffer (head plus skid), so a result passes
// the input register and then the output buffer before it shows on rsp_;
// one event is taken every cycle while req_stall is low.
// req_stall rises only when the skid is full and the waiting event would
// produce a beat. Registers: device_address at 0x0, probe_timeout_ticks at
// 0x4; write them only while no transaction is running.
module i2c_motor_link_controller_unit
   import imlc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // event channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_type,
   input  logic signed [13:0]    req_speed_value,
   input  logic [7:0]            req_setting_byte,
   input  logic [7:0]            req_bus_status,
   input  logic [7:0]            req_rx_byte,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_bus_command,
   output logic [7:0]            rsp_bus_byte,
   output logic                  rsp_done_res,
   output logic                  rsp_success,
   output logic                  rsp_device_present,
   output logic signed [31:0]    rsp_encoder_count,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cfg_type      cfg;
   req_item_type in_item_ff, in_item_in;
   logic         in_vld_ff,  in_vld_in;
   logic         emit;
   logic         go;
   logic         fire;
   logic         full;
   rsp_item_type seq_rsp;
   rsp_item_type head;

   imlc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The held event moves on unless it would emit a beat into a full buffer
   assign go        = ~emit | ~full;
   assign fire      = in_vld_ff & go;
   assign req_stall = in_vld_ff & ~go;

   always_comb begin
      in_item_in.kind         = req_type;
      in_item_in.speed_value  = req_speed_value;
      in_item_in.setting_byte = req_setting_byte;
      in_item_in.bus_status   = req_bus_status;
      in_item_in.rx_byte      = req_rx_byte;
      // Hold the register while stalled, else load the next beat (or go empty)
      in_vld_in = req_stall ? in_vld_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= in_item_in;
      end
   end

   imlc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .item  (in_item_ff),
      .fire  (fire),
      .emit  (emit),
      .rsp   (seq_rsp)
   );

   imlc_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (fire & emit),
      .push_data (seq_rsp),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_bus_command    = head.bus_command;
   assign rsp_bus_byte       = head.bus_byte;
   assign rsp_done_res       = head.done_res;
   assign rsp_success        = head.success;
   assign rsp_device_present = head.device_present;
   assign rsp_encoder_count  = head.encoder_count;

endmodule

// File: rtl/core/imlc_checker.sv
module imlc_checker
   import imlc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [2:0]            rsp_bus_command,
   input logic [7:0]            rsp_bus_byte,
   input logic                  rsp_done_res,
   input logic                  rsp_success,
   input logic                  rsp_device_present,
   input logic signed [31:0]    rsp_encoder_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bus_command)
         && $stable(rsp_bus_byte) && $stable(rsp_done_res)
         && $stable(rsp_encoder_count))
      else $error("result beat changed while stalled");

   a_done_is_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_bus_command == CMD_STOP)
      else $error("finishing beat without stop");

   a_flags_need_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> !rsp_success && !rsp_device_present
         && rsp_encoder_count == 32'sd0)
      else $error("result flags set on a non-final beat");

   a_present_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_device_present |-> rsp_success)
      else $error("device present without success");

   a_byte_send_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_byte != 8'd0 |-> rsp_bus_command == CMD_SEND)
      else $error("bus byte on a non-send command");

endmodule

bind i2c_motor_link_controller_unit imlc_checker u_imlc_checker (.*);

// File: tb/link_check_pkg.sv
package link_check_pkg;
   import imlc_pkg::*;

   typedef enum logic [2:0] {
      LINK_IDLE,
      LINK_START,
      LINK_ADDR,
      LINK_DATA,
      LINK_RX
   } link_phase_type;

   class link_scoreboard;
      logic [6:0]     dev_addr;
      logic [15:0]    timeout_ticks;
      link_phase_type phase;
      logic [2:0]     active_kind;
      logic [1:0]     byte_idx;
      logic [7:0]     high_byte;
      logic [7:0]     low_byte;
      logic [31:0]    enc_acc;
      logic [15:0]    tick_cnt;
      rsp_item_type   bus_beat_q[$];
      int             mismatches;

      function new();
         dev_addr      = DEVADDR_RESET;
         timeout_ticks = TIMEOUT_RESET;
         phase         = LINK_IDLE;
         active_kind   = REQ_SPEED;
         byte_idx      = '0;
         high_byte     = '0;
         low_byte      = '0;
         enc_acc       = '0;
         tick_cnt      = '0;
         mismatches    = 0;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      function void queue_beat(logic [2:0] cmd, logic [7:0] data, logic done, logic ok,
                               logic present, logic [31:0] count);
         rsp_item_type r;
         r.bus_command    = cmd;
         r.bus_byte       = data;
         r.done_res       = done;
         r.success        = ok;
         r.device_present = present;
         r.encoder_count  = count;
         bus_beat_q.push_back(r);
      endfunction

      // Close the transaction with a stop.
      function void close_out(logic ok, logic present, logic [31:0] count);
         phase    = LINK_IDLE;
         byte_idx = '0;
         tick_cnt = '0;
         queue_beat(CMD_STOP, 8'h00, 1'b1, ok, present, count);
      endfunction

      function void take_status(logic [7:0] st, logic [7:0] rx);
         case (phase)
            LINK_START: begin
               if (st != ST_START) begin
                  close_out(1'b0, 1'b0, '0);
               end else begin
                  phase    = LINK_ADDR;
                  tick_cnt = '0;
                  queue_beat(CMD_SEND, {dev_addr, active_kind == REQ_ENCODER},
                             1'b0, 1'b0, 1'b0, '0);
               end
            end
            LINK_ADDR: begin
               if (active_kind == REQ_PROBE) begin
                  if (st == ST_SLAW) close_out(1'b1, 1'b1, '0);
                  else close_out(1'b0, 1'b0, '0);
               end else if (st != ST_SLAW && st != ST_SLAR) begin
                  close_out(1'b0, 1'b0, '0);
               end else begin
                  byte_idx = '0;
                  if (active_kind == REQ_ENCODER) begin
                     phase   = LINK_RX;
                     enc_acc = '0;
                     queue_beat(CMD_RXACK, 8'h00, 1'b0, 1'b0, 1'b0, '0);
                  end else begin
                     phase = LINK_DATA;
                     queue_beat(CMD_SEND, (active_kind == REQ_SPEED) ? high_byte : low_byte,
                                1'b0, 1'b0, 1'b0, '0);
                  end
               end
            end
            LINK_DATA: begin
               if (st != ST_TXDATA) begin
                  close_out(1'b0, 1'b0, '0);
               end else if (active_kind == REQ_SPEED && byte_idx == 2'd0) begin
                  byte_idx = 2'd1;
                  queue_beat(CMD_SEND, low_byte, 1'b0, 1'b0, 1'b0, '0);
               end else begin
                  close_out(1'b1, 1'b0, '0);
               end
            end
            LINK_RX: begin
               if (byte_idx < 2'd3) begin
                  if (st != ST_RXACK) begin
                     close_out(1'b0, 1'b0, '0);
                  end else begin
                     // big-endian: first byte lands in the top lane
                     enc_acc  = enc_acc | (32'(rx) << (8 * (3 - int'(byte_idx))));
                     byte_idx = byte_idx + 2'd1;
                     queue_beat((byte_idx == 2'd3) ? CMD_RXNAK : CMD_RXACK,
                                8'h00, 1'b0, 1'b0, 1'b0, '0);
                  end
               end else if (st != ST_RXNAK) begin
                  close_out(1'b0, 1'b0, '0);
               end else begin
                  enc_acc = enc_acc | 32'(rx);
                  close_out(1'b1, 1'b0, enc_acc);
               end
            end
            default: ;
         endcase
      endfunction

      // Advance the model by one accepted event. Returns 1 if the event did any work.
      function bit note_event(req_item_type ev);
         logic [13:0] raw;
         logic        neg;
         logic [14:0] mag;
         case (ev.kind)
            REQ_SPEED, REQ_SETTING, REQ_ENCODER, REQ_PROBE: begin
               if (phase != LINK_IDLE) return 1'b0;
               active_kind = ev.kind;
               byte_idx    = '0;
               tick_cnt    = '0;
               enc_acc     = '0;
               high_byte   = '0;
               low_byte    = '0;
               if (ev.kind == REQ_SPEED) begin
                  raw = ev.speed_value;
                  neg = raw[13];
                  mag = neg ? (15'd16384 - {1'b0, raw}) : {1'b0, raw};
                  if (mag > 15'd4095) mag = 15'd4095;
                  high_byte = {2'b00, neg, mag[11:7]};
                  low_byte  = {1'b1, mag[6:0]};
               end else if (ev.kind == REQ_SETTING) begin
                  low_byte = ev.setting_byte;
               end
               phase = LINK_START;
               queue_beat(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0, '0);
               return 1'b1;
            end
            REQ_STATUS: begin
               if (phase == LINK_IDLE) return 1'b0;
               take_status(ev.bus_status & ST_MASK, ev.rx_byte);
               return 1'b1;
            end
            REQ_TICK: begin
               if (phase != LINK_ADDR || active_kind != REQ_PROBE) return 1'b0;
               if (tick_cnt >= timeout_ticks) close_out(1'b0, 1'b0, '0);
               else tick_cnt = tick_cnt + 16'd1;
               return 1'b1;
            end
            default: return 1'b0;
         endcase
      endfunction

      task check_result(rsp_item_type got);
         rsp_item_type want;
         if (bus_beat_q.size() == 0) begin
            report($sformatf("unexpected beat, cmd %0d byte %02h", got.bus_command,
                             got.bus_byte));
            return;
         end
         want = bus_beat_q.pop_front();
         if (got.bus_command !== want.bus_command)
            report($sformatf("bus_command %0d, want %0d", got.bus_command, want.bus_command));
         if (got.bus_byte !== want.bus_byte)
            report($sformatf("bus_byte %02h, want %02h", got.bus_byte, want.bus_byte));
         if (got.done_res !== want.done_res)
            report($sformatf("done_res %0b, want %0b", got.done_res, want.done_res));
         if (got.success !== want.success)
            report($sformatf("success %0b, want %0b", got.success, want.success));
         if (got.device_present !== want.device_present)
            report($sformatf("device_present %0b, want %0b", got.device_present,
                             want.device_present));
         if (got.encoder_count !== want.encoder_count)
            report($sformatf("encoder_count %08h, want %08h", got.encoder_count,
                             want.encoder_count));
      endtask
   endclass

endpackage

// File: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import imlc_pkg::*;
   import link_check_pkg::*;

   // Request codes the block must ignore
   localparam logic [2:0] REQ_SPARE_LO = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;
   // A status that no phase accepts: drives the failure paths
   localparam logic [7:0] ST_BOGUS     = 8'h20;

   localparam logic [CSR_ADDR_W-1:0] CSR_DEVADDR_OFS = {CSR_IDX_DEVADDR, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT_OFS = {CSR_IDX_TIMEOUT, 2'b00};

   localparam int PHASE_EVENTS = 250;     // working events per random phase
   localparam int NUM_PHASES   = 4;
   localparam int DRAIN_CYCLES = 8;       // input register and output buffer plus margin
   localparam int CYCLE_LIMIT  = 200000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [2:0]            req_type;
   logic signed [13:0]    req_speed_value;
   logic [7:0]            req_setting_byte;
   logic [7:0]            req_bus_status;
   logic [7:0]            req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [2:0]            rsp_bus_command;
   logic [7:0]            rsp_bus_byte;
   logic                  rsp_done_res;
   logic                  rsp_success;
   logic                  rsp_device_present;
   logic signed [31:0]    rsp_encoder_count;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   link_scoreboard sb = new();
   bit             calm_tail;      // no idling on either side once set
   int             cycle_cnt;
   int             stall_left;
   rsp_item_type   seen_beat;

   i2c_motor_link_controller_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("** i2c_motor_link_controller_unit: FAILED **");
         $finish;
      end
   end

   // Result side: check every accepted beat, then pick the next stall value.
   // Stalls come in bursts of random length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_beat.bus_command    = rsp_bus_command;
            seen_beat.bus_byte       = rsp_bus_byte;
            seen_beat.done_res       = rsp_done_res;
            seen_beat.success        = rsp_success;
            seen_beat.device_present = rsp_device_present;
            seen_beat.encoder_count  = rsp_encoder_count;
            sb.check_result(seen_beat);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [2:0] pick_request();
      case ($urandom_range(0, 3))
         0:       return REQ_SPEED;
         1:       return REQ_SETTING;
         2:       return REQ_ENCODER;
         default: return REQ_PROBE;
      endcase
   endfunction

   // Status that moves the running transaction forward, junk in the masked bits.
   function automatic logic [7:0] good_status();
      logic [7:0] code;
      case (sb.phase)
         LINK_START: code = ST_START;
         LINK_ADDR:  code = (sb.active_kind == REQ_PROBE || $urandom_range(0, 1)) ?
                            ST_SLAW : ST_SLAR;
         LINK_DATA:  code = ST_TXDATA;
         LINK_RX:    code = (sb.byte_idx < 2'd3) ? ST_RXACK : ST_RXNAK;
         default:    code = ST_START;
      endcase
      return code | 8'($urandom_range(0, 7));
   endfunction

   // Mostly well-formed traffic for whatever phase the link is in, with noise:
   // wrong statuses, ticks, requests while busy and unused codes.
   function automatic req_item_type make_event();
      req_item_type ev;
      int           roll;
      int           speed;
      ev.kind         = REQ_STATUS;
      ev.speed_value  = 14'($urandom);
      ev.setting_byte = 8'($urandom);
      ev.bus_status   = 8'($urandom);
      ev.rx_byte      = 8'($urandom);
      roll            = $urandom_range(0, 99);
      if (sb.phase == LINK_IDLE) begin
         if (roll < 88) ev.kind = pick_request();
         else if (roll < 92) ev.kind = REQ_STATUS;
         else if (roll < 96) ev.kind = REQ_TICK;
         else ev.kind = roll[0] ? REQ_SPARE_LO : REQ_SPARE_HI;
         // keep most speeds in the legal range, the rest span all 14 bits
         if ($urandom_range(0, 3) != 0) begin
            speed          = int'($urandom_range(0, 8192)) - 4096;
            ev.speed_value = 14'(speed);
         end
      end else if (sb.phase == LINK_ADDR && sb.active_kind == REQ_PROBE && roll < 45) begin
         ev.kind = REQ_TICK;
      end else if (roll < 82) begin
         ev.bus_status = good_status();
      end else if (roll < 90) begin
         ev.kind = REQ_STATUS;
      end else if (roll < 95) begin
         ev.kind = REQ_TICK;
      end else begin
         ev.kind = pick_request();
      end
      return ev;
   endfunction

   // Present one event beat and hold it until accepted; valid stays high after.
   task automatic send_beat(input req_item_type ev, output bit counted);
      int gap;
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= ev.kind;
      req_speed_value  <= ev.speed_value;
      req_setting_byte <= ev.setting_byte;
      req_bus_status   <= ev.bus_status;
      req_rx_byte      <= ev.rx_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      counted = sb.note_event(ev);
   endtask

   task automatic push_event(logic [2:0] kind, int speed, logic [7:0] setting,
                             logic [7:0] status, logic [7:0] rx);
      req_item_type ev;
      bit           counted;
      ev.kind         = kind;
      ev.speed_value  = 14'(speed);
      ev.setting_byte = setting;
      ev.bus_status   = status;
      ev.rx_byte      = rx;
      send_beat(ev, counted);
   endtask

   // Drop valid and wait out every expected beat plus the pipeline depth.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.bus_beat_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(logic [6:0] addr7, logic [15:0] ticks);
      csr_write(CSR_DEVADDR_OFS, {25'd0, addr7});
      csr_write(CSR_TIMEOUT_OFS, {16'd0, ticks});
      sb.dev_addr      = addr7;
      sb.timeout_ticks = ticks;
   endtask

   initial begin
      int           done_cnt;
      bit           counted;
      req_item_type ev;

      // Drive every input but rsp_stall to a known value before the first edge.
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_type         <= REQ_STATUS;
      req_speed_value  <= '0;
      req_setting_byte <= '0;
      req_bus_status   <= '0;
      req_rx_byte      <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      calm_tail        = 1'b0;
      cycle_cnt        = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, registers at their reset values.
      // Stray events while idle: status, tick and both unused codes give nothing.
      push_event(REQ_STATUS, 0, 8'h00, ST_START, 8'h00);
      push_event(REQ_TICK, 0, 8'h00, 8'h00, 8'h00);
      push_event(REQ_SPARE_LO, 0, 8'h00, 8'h00, 8'h00);
      push_event(REQ_SPARE_HI, 0, 8'h00, 8'h00, 8'h00);
      // A speed of -4096 saturates; a request in the middle is ignored.
      push_event(REQ_SPEED, -4096, 8'h00, 8'h00, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_START, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_SLAW | 8'h07, 8'h00);
      push_event(REQ_SETTING, 0, 8'hFF, 8'h00, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_TXDATA, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_TXDATA, 8'h00);
      // Full encoder read with both extremes of the received byte.
      push_event(REQ_ENCODER, 0, 8'h00, 8'h00, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_START, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_SLAR, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_RXACK, 8'hFF);
      push_event(REQ_STATUS, 0, 8'h00, ST_RXACK, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_RXACK | 8'h07, 8'hA5);
      push_event(REQ_STATUS, 0, 8'h00, ST_RXNAK, 8'h5A);
      // Probe that sees a tick, then the address acknowledged.
      push_event(REQ_PROBE, 0, 8'h00, 8'h00, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_START, 8'h00);
      push_event(REQ_TICK, 0, 8'h00, 8'h00, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_SLAW, 8'h00);
      // Probe whose start fails reports the device absent.
      push_event(REQ_PROBE, 0, 8'h00, 8'h00, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_BOGUS, 8'h00);
      // Setting byte whose address is not acknowledged.
      push_event(REQ_SETTING, 0, 8'hFF, 8'h00, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_START, 8'h00);
      push_event(REQ_STATUS, 0, 8'h00, ST_BOGUS, 8'h00);
      settle();

      // Random phases, each under its own register setting; the last runs flat out.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       configure(7'h7F, 16'd1);
            1:       configure(7'h2A, 16'hFFFF);
            2:       configure(7'h55, 16'd3);
            default: configure(7'h00, 16'd2);
         endcase
         calm_tail = (p == NUM_PHASES - 1);
         done_cnt  = 0;
         while (done_cnt < PHASE_EVENTS) begin
            send_beat(make_event(), counted);
            if (counted) done_cnt++;
         end
         // Finish any open transaction so the next register write lands while idle.
         while (sb.phase != LINK_IDLE) begin
            ev            = make_event();
            ev.kind       = REQ_STATUS;
            ev.bus_status = good_status();
            send_beat(ev, counted);
         end
         settle();
      end

      if (sb.mismatches == 0) begin
         $display("** i2c_motor_link_controller_unit: PASSED **");
      end else begin
         $display("** i2c_motor_link_controller_unit: FAILED **");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/imlc_pkg.sv
rtl/core/imlc_csr.sv
rtl/core/imlc_seq.sv
rtl/core/imlc_rspq.sv
rtl/core/i2c_motor_link_controller_unit.sv
rtl/core/imlc_checker.sv
tb/link_check_pkg.sv
tb/tb_top.sv
